// File: design/assert_macros.svh
// Assertion macros used by the resampler datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define SRS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Trigger implies the consequent in the next cycle.
`define SRS_ASSERT_NEXT(label, clk, rst, trig, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
      else $error(msg);

`endif

// File: design/srs_pkg.sv
// Shared widths and controller/datapath interface types for the resampler.
package srs_pkg;

   localparam int MAX_PARTICLES = 64;
   localparam int IDX_W         = 6;   // particle index
   localparam int CNT_W         = 7;   // count up to MAX_PARTICLES
   localparam int W_W           = 16;  // weight and start fraction
   localparam int TOT_W         = 22;  // sum of up to 64 weights
   localparam int FT_W          = W_W + TOT_W;   // start fraction times total
   localparam int NW_W          = CNT_W + W_W;   // count times weight
   localparam int ACC_W         = 46;  // scaled threshold and cumulative weight

   typedef struct packed {
      logic store;      // weight transfer accepted
      logic start;      // capture set size and total, clear the load counters
      logic rd_first;   // read the first store entry
      logic init;       // load cumulative weight with the first entry
      logic advance;    // step the pointer and add the next weight
      logic emit;       // load one result into the output register
      logic zero_mode;  // identity mapping for zero total
   } cmd_type;

   typedef struct packed {
      logic n_zero;     // no weights held
      logic tot_zero;   // held weights sum to zero
      logic cond;       // pointer must advance before the current slot
      logic last_slot;  // current slot is the final one
      logic out_free;   // output register can take a result this cycle
   } status_type;

endpackage

// File: design/srs_ctrl.sv
// Sequencer for loading weights and running the resampling sweep.
module srs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tlast,
   output logic                 req_tready,
   input  srs_pkg::status_type  st,
   output srs_pkg::cmd_type     cmd
);
   import srs_pkg::*;

   localparam logic [2:0] S_LOAD  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_INIT  = 3'd2;
   localparam logic [2:0] S_WAIT  = 3'd3;
   localparam logic [2:0] S_CMP   = 3'd4;
   localparam logic [2:0] S_ZERO  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_LOAD: begin
            cmd.store = req_tvalid;
            if (req_tvalid && req_tlast) begin
               state_in = S_START;
            end
         end
         S_START: begin
            cmd.start    = 1'b1;
            cmd.rd_first = 1'b1;
            priority if (st.n_zero) begin
               state_in = S_LOAD;
            end else if (st.tot_zero) begin
               state_in = S_ZERO;
            end else begin
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            cmd.init = 1'b1;
            state_in = S_CMP;
         end
         S_WAIT: begin
            // next weight read is in flight
            state_in = S_CMP;
         end
         S_CMP: begin
            priority if (st.cond) begin
               cmd.advance = 1'b1;
               state_in    = S_WAIT;
            end else if (st.out_free) begin
               cmd.emit = 1'b1;
               if (st.last_slot) begin
                  state_in = S_LOAD;
               end
            end else begin
               // hold until the output register frees
               state_in = S_CMP;
            end
         end
         S_ZERO: begin
            cmd.zero_mode = 1'b1;
            if (st.out_free) begin
               cmd.emit = 1'b1;
               if (st.last_slot) begin
                  state_in = S_LOAD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_LOAD);

endmodule

// File: design/srs_dpath.sv
// Weight store, accumulators, pointer and output register of the resampler.
module srs_dpath (
   input  logic                         clock,
   input  logic                         reset,
   input  srs_pkg::cmd_type             cmd,
   input  logic [srs_pkg::W_W-1:0]      weight_in,
   input  logic [srs_pkg::W_W-1:0]      frac_in,
   output srs_pkg::status_type          st,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic [srs_pkg::IDX_W-1:0]    rsp_index,
   output logic                         rsp_zero,
   output logic                         rsp_last
);
   import srs_pkg::*;
`include "assert_macros.svh"

   logic [W_W-1:0]   mem [MAX_PARTICLES];
   logic [W_W-1:0]   rd_ff;
   logic [IDX_W-1:0] rd_addr;

   logic [CNT_W-1:0] cnt_ff;
   logic [TOT_W-1:0] tot_ff;
   logic [W_W-1:0]   frac_ff;
   logic [CNT_W-1:0] n_ff;
   logic [TOT_W-1:0] stot_ff;
   logic [ACC_W-1:0] thr_ff;
   logic [ACC_W-1:0] nc_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] m_ff;

   logic             rsp_valid_ff;
   logic [IDX_W-1:0] rsp_index_ff;
   logic             rsp_zero_ff;
   logic             rsp_last_ff;

   logic             full;
   logic [FT_W-1:0]  ft;
   logic [NW_W-1:0]  nw;
   logic [ACC_W-1:0] nw_scaled;
   logic [ACC_W-1:0] step_scaled;
   logic [CNT_W-1:0] n_less;

   assign full        = (cnt_ff == CNT_W'(MAX_PARTICLES));
   assign ft          = frac_ff * tot_ff;
   assign nw          = n_ff * rd_ff;
   assign nw_scaled   = {{(ACC_W - NW_W - W_W){1'b0}}, nw, {W_W{1'b0}}};
   assign step_scaled = {{(ACC_W - TOT_W - W_W){1'b0}}, stot_ff, {W_W{1'b0}}};
   assign n_less      = n_ff - CNT_W'(1);
   assign rd_addr     = cmd.rd_first ? '0 : idx_ff + IDX_W'(1);

   assign st.n_zero    = (cnt_ff == '0);
   assign st.tot_zero  = (tot_ff == '0);
   assign st.cond      = (thr_ff > nc_ff) && ({1'b0, idx_ff} < n_less);
   assign st.last_slot = ({1'b0, m_ff} == n_less);
   assign st.out_free  = !rsp_valid_ff || rsp_ready;

   // weight store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.store && !full) begin
         mem[cnt_ff[IDX_W-1:0]] <= weight_in;
      end
      rd_ff <= mem[rd_addr];
   end

   // load counters
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         tot_ff <= '0;
      end else if (cmd.start) begin
         cnt_ff <= '0;
         tot_ff <= '0;
      end else if (cmd.store && !full) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
         tot_ff <= tot_ff + {{(TOT_W - W_W){1'b0}}, weight_in};
      end
   end

   // sweep registers
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         frac_ff <= frac_in;
      end
      if (cmd.start) begin
         n_ff    <= cnt_ff;
         stot_ff <= tot_ff;
         thr_ff  <= {{(ACC_W - FT_W){1'b0}}, ft};
         idx_ff  <= '0;
         m_ff    <= '0;
      end else begin
         if (cmd.init) begin
            nc_ff <= nw_scaled;
         end else if (cmd.advance) begin
            nc_ff  <= nc_ff + nw_scaled;
            idx_ff <= idx_ff + IDX_W'(1);
         end
         if (cmd.emit) begin
            thr_ff <= thr_ff + step_scaled;
            m_ff   <= m_ff + IDX_W'(1);
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_index_ff <= cmd.zero_mode ? m_ff : idx_ff;
         rsp_zero_ff  <= cmd.zero_mode;
         rsp_last_ff  <= st.last_slot;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_index = rsp_index_ff;
   assign rsp_zero  = rsp_zero_ff;
   assign rsp_last  = rsp_last_ff;

   `SRS_ASSERT(emit_needs_room, clock, reset, !cmd.emit || st.out_free, "result overwrote a pending transfer")
   `SRS_ASSERT(emit_in_range, clock, reset, !cmd.emit || ({1'b0, m_ff} < n_ff), "slot counter ran past set size")
   `SRS_ASSERT_NEXT(advance_in_range, clock, reset, cmd.advance, {1'b0, idx_ff} < n_ff, "pointer ran past set size")

endmodule

// File: design/systematic_resampler_core.sv
// Top level of the systematic resampler: weight loading and resampling sweep.
//
// Weights stream in on the req_ channel, one transfer per cycle while loading,
// and are held in a 64-entry store with a running total; transfers beyond 64
// are dropped but a transfer marked tlast still closes the set. The last
// transfer also carries the start fraction. The block then stops taking input
// and sweeps the set, sending one source index per held particle on the rsp_
// channel with tlast on the final slot. The sweep first captures the set, then
// loads the first cumulative weight; each pointer step is a registered store
// read followed by the cumulative-weight update, and each output slot waits
// while the output register is held by a low rsp_tready. A set with zero total
// goes from the setup step straight to emitting indices 0..n-1 with tuser set,
// one per cycle unless the output register is held. Input is taken again once
// the final slot is loaded into the output register.
module systematic_resampler_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [15:0] weight, [31:16] start_fraction
   input  logic        req_tlast,    // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // [5:0] source_index, [7:6] zero
   output logic        rsp_tuser,    // all_zero
   output logic        rsp_tlast     // last_res
);
   import srs_pkg::*;

   cmd_type          cmd;
   status_type       st;
   logic [IDX_W-1:0] rsp_index;

   srs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   srs_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .weight_in (req_tdata[W_W-1:0]),
      .frac_in   (req_tdata[2*W_W-1:W_W]),
      .st        (st),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_index (rsp_index),
      .rsp_zero  (rsp_tuser),
      .rsp_last  (rsp_tlast)
   );

   // pad the index up to a whole byte
   assign rsp_tdata = {{(8 - IDX_W){1'b0}}, rsp_index};

endmodule

// File: sim/systematic_resampler_checker.sv
// Channel monitor, sweep predictor and result comparison for the resampler core.
`timescale 1ns / 100ps

module systematic_resampler_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [31:0]       req_tdata,       // [15:0] weight, [31:16] start_fraction
   input  logic              req_tlast,       // last
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [7:0]        rsp_tdata,       // [5:0] source_index, [7:6] zero
   input  logic              rsp_tuser,       // all_zero
   input  logic              rsp_tlast,       // last_res
   output int unsigned       mismatch_count,
   output int unsigned       slots_waiting,
   output int unsigned       slots_checked
);
   import srs_pkg::*;

   typedef struct packed {
      logic [IDX_W-1:0] source_index;
      logic             all_zero;
      logic             last_res;
   } slot_type;

   // Predictor copy of the particle set being loaded.
   logic [W_W-1:0]   held_weight [MAX_PARTICLES];
   int unsigned      held_count;
   logic [TOT_W-1:0] held_total;

   slot_type    chosen_slots [$];   // predicted index slots, oldest first
   int unsigned mismatches;
   int unsigned compared;

   function automatic void queue_slot(input int unsigned idx, input logic zero,
                                      input logic fin);
      slot_type s;
      s.source_index = IDX_W'(idx);
      s.all_zero     = zero;
      s.last_res     = fin;
      chosen_slots   = {chosen_slots, s};
   endfunction

   function automatic void compare_field(input string field, input int unsigned want,
                                         input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endfunction

   // Store one weight; on the closing weight run the sweep in scaled integers.
   task automatic take_weight(input logic [W_W-1:0] w, input logic [W_W-1:0] frac,
                              input logic closes);
      int unsigned n;
      int unsigned ptr;
      bit [63:0]   thr;
      bit [63:0]   scale;
      bit [63:0]   stride;
      bit [63:0]   cum;
      bit [63:0]   total;
      if (held_count < MAX_PARTICLES) begin
         held_weight[held_count] = w;
         held_count++;
         held_total = held_total + TOT_W'(w);
      end
      if (!closes)
         return;
      n          = held_count;
      total      = 64'(held_total);
      held_count = 0;
      held_total = '0;
      if (n == 0)
         return;
      if (total == 0) begin
         for (int unsigned m = 0; m < n; m++)
            queue_slot(m, 1'b1, m == n - 1);
         return;
      end
      scale  = 64'(n) << 16;
      stride = total << 16;
      thr    = 64'(frac) * total;
      cum    = 64'(held_weight[0]);
      ptr    = 0;
      for (int unsigned m = 0; m < n; m++) begin
         while (thr > scale * cum && ptr < n - 1) begin
            ptr++;
            cum = cum + 64'(held_weight[ptr]);
         end
         queue_slot(ptr, 1'b0, m == n - 1);
         thr = thr + stride;
      end
   endtask

   always @(posedge clock) begin
      slot_type want;
      if (reset) begin
         held_count = 0;
         held_total = '0;
         chosen_slots.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (chosen_slots.size() == 0) begin
               $error("source_index: expected none, got %0d", rsp_tdata[IDX_W-1:0]);
               mismatches++;
            end else begin
               want = chosen_slots.pop_front();
               compare_field("source_index", want.source_index, rsp_tdata[IDX_W-1:0]);
               compare_field("all_zero", want.all_zero, rsp_tuser);
               compare_field("last_res", want.last_res, rsp_tlast);
               compared++;
            end
         end
         if (req_tvalid && req_tready)
            take_weight(req_tdata[W_W-1:0], req_tdata[2*W_W-1:W_W], req_tlast);
      end
      mismatch_count <= mismatches;
      slots_waiting  <= chosen_slots.size();
      slots_checked  <= compared;
   end

endmodule

// File: sim/systematic_resampler_core_tb.sv
// Stimulus, handshake pacing and verdict for the systematic resampler core.
`timescale 1ns / 100ps

module systematic_resampler_core_tb;
   import srs_pkg::*;

   // Hold-off of the result side: long enough for a full sweep to back up
   // into the output register and stall the weight channel behind it.
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned RANDOM_ITEMS = 200;
   localparam int unsigned DRAIN_CYCLES = 20;

   typedef enum int unsigned {
      PAT_UNIFORM,   // any 16-bit weight
      PAT_ZERO,      // whole set at zero total
      PAT_SPARSE,    // mostly zero, a few survivors
      PAT_TINY,      // weights 0..3, many ties and fine steps
      PAT_EXTREME    // only 0 and full scale
   } weight_pattern_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;     // [15:0] weight, [31:16] start_fraction
   logic        req_tlast;     // last
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;     // [5:0] source_index, [7:6] zero
   logic        rsp_tuser;     // all_zero
   logic        rsp_tlast;     // last_res

   int unsigned mismatch_count;
   int unsigned slots_waiting;
   int unsigned slots_checked;

   // Pacing knobs shared between the weight sender and the result receiver.
   // Written with nonblocking assignments so the receiver reads them race-free.
   logic        calm;
   int unsigned hold_requests;

   logic [W_W-1:0] set_weights [$];   // weights of the next set, in send order
   int unsigned    sets_sent;
   int unsigned    zero_sets;
   int unsigned    overflow_sets;
   int unsigned    random_items;

   systematic_resampler_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   systematic_resampler_checker index_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .slots_waiting  (slots_waiting),
      .slots_checked  (slots_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Gap length: mostly none or short, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 10);
      else
         return $urandom_range(11, 40);
   endfunction

   function automatic logic [W_W-1:0] draw_weight(input weight_pattern_type pattern);
      case (pattern)
         PAT_ZERO:    return '0;
         PAT_SPARSE:  return ($urandom_range(0, 9) < 7) ? '0 : W_W'($urandom);
         PAT_TINY:    return W_W'($urandom_range(0, 3));
         PAT_EXTREME: return $urandom_range(0, 1) ? '1 : '0;
         default:     return W_W'($urandom);
      endcase
   endfunction

   // Offer one weight, hold it until the transfer, then idle for a random gap.
   task automatic send_weight(input logic [W_W-1:0] w, input logic [W_W-1:0] frac,
                              input logic closes);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {frac, w};
      req_tlast  <= closes;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      gap = calm ? 0 : pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Send the staged set; the final weight closes it and carries the start fraction.
   // Non-final weights carry a random start fraction that the block must ignore.
   task automatic send_staged(input logic [W_W-1:0] frac);
      int unsigned sum;
      int unsigned size;
      sum  = 0;
      size = set_weights.size();
      for (int unsigned k = 0; k < size; k++) begin
         if (k < MAX_PARTICLES)
            sum += set_weights[k];
         send_weight(set_weights[k], (k == size - 1) ? frac : W_W'($urandom), k == size - 1);
      end
      sets_sent++;
      if (sum == 0)
         zero_sets++;
      if (size > MAX_PARTICLES)
         overflow_sets++;
   endtask

   // Pause the sender until every predicted slot has been transferred.
   // Drop the request first so the last weight is not offered again.
   // The extra edge lets the checker's count reflect the last weight transfer.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (slots_waiting != 0)
         @(posedge clock);
   endtask

   // Build a random set of the given size with a randomly chosen weight pattern.
   task automatic stage_random_set(input int unsigned size);
      weight_pattern_type pattern;
      int unsigned        r;
      r = $urandom_range(0, 99);
      if (r < 45)
         pattern = PAT_UNIFORM;
      else if (r < 55)
         pattern = PAT_ZERO;
      else if (r < 75)
         pattern = PAT_SPARSE;
      else if (r < 88)
         pattern = PAT_TINY;
      else
         pattern = PAT_EXTREME;
      set_weights.delete();
      repeat (size) set_weights = {set_weights, draw_weight(pattern)};
   endtask

   function automatic logic [W_W-1:0] draw_fraction();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 10)
         return '0;
      else if (r < 20)
         return '1;
      else
         return W_W'($urandom);
   endfunction

   // Result side: ready most cycles, random stalls of mixed length, ready in calm
   // phases unless a hold-off is pending, and a long hold-off whenever the stimulus asks.
   initial begin
      int unsigned hold_served;
      int unsigned span;
      hold_served = 0;
      forever begin
         if (hold_served != hold_requests) begin
            hold_served++;
            rsp_tready <= 1'b0;
            span = HOLD_CYCLES;
         end else if (calm || $urandom_range(0, 3) != 0) begin
            rsp_tready <= 1'b1;
            span = 1;
         end else begin
            rsp_tready <= 1'b0;
            span = pick_gap() + 1;
         end
         repeat (span) @(posedge clock);
      end
   end

   // Main stimulus.
   initial begin
      int unsigned size;
      int unsigned set_no;
      reset         <= 1'b1;
      req_tvalid    <= 1'b0;
      req_tdata     <= '0;
      req_tlast     <= 1'b0;
      calm          <= 1'b0;
      hold_requests <= 0;
      sets_sent     = 0;
      zero_sets     = 0;
      overflow_sets = 0;
      random_items  = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed sets: single particle at full scale, single zero weight, zero total
      // over several particles, extreme weights at a zero start fraction, a lone survivor
      // at the end, a heavy middle weight between small ones, alternating bit patterns.
      set_weights = {16'hFFFF};
      send_staged(16'hFFFF);
      set_weights = {16'h0000};
      send_staged(16'h0000);
      set_weights = {16'h0000, 16'h0000, 16'h0000};
      send_staged(16'h1234);
      set_weights = {16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF};
      send_staged(16'h0000);
      set_weights = {16'h0000, 16'h0000, 16'h0000, 16'h0001};
      send_staged(16'hFFFF);
      set_weights = {16'h0001, 16'hFFFF, 16'h0001};
      send_staged(16'h8000);
      set_weights = {16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00};
      send_staged(16'hAAAA);
      wait_drained();

      // Random sets, mostly small; a few fill the 64-entry store or run past it
      // so the extra weights, including the closing one, are dropped.
      set_no = 0;
      while (random_items < RANDOM_ITEMS) begin
         if (set_no == 2)
            size = MAX_PARTICLES;
         else if (set_no == 5)
            size = MAX_PARTICLES + 5;
         else if ($urandom_range(0, 99) < 85)
            size = $urandom_range(1, 10);
         else if ($urandom_range(0, 99) < 60)
            size = $urandom_range(11, 24);
         else
            size = $urandom_range(MAX_PARTICLES, MAX_PARTICLES + 6);

         if (set_no == 1) begin
            // Hold off the result side while two sets go in back to back:
            // the first sweep backs up and the second set stalls on req_tready.
            wait_drained();
            calm          <= 1'b1;
            hold_requests <= hold_requests + 1;
            stage_random_set(8);
            send_staged(draw_fraction());
            stage_random_set(8);
            send_staged(draw_fraction());
            random_items += 16;
            wait_drained();
            calm <= 1'b0;
         end else begin
            // Some sets run with no idling on either side.
            calm <= ($urandom_range(0, 99) < 15);
            stage_random_set(size);
            send_staged(draw_fraction());
            random_items += size;
            if ($urandom_range(0, 99) < 20)
               wait_drained();
         end
         set_no++;
      end

      req_tlast  <= 1'b0;
      calm       <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Swept %0d weight sets: %0d with zero total, %0d past the full store.",
               sets_sent, zero_sets, overflow_sets);
      $display("Compared %0d source index slots.", slots_checked);
      if (slots_waiting != 0)
         $error("%0d predicted index slots never arrived", slots_waiting);
      if (mismatch_count == 0 && slots_waiting == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #3000000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// File: sim.f
+incdir+design
design/srs_pkg.sv
design/srs_ctrl.sv
design/srs_dpath.sv
design/systematic_resampler_core.sv
sim/systematic_resampler_checker.sv
sim/systematic_resampler_core_tb.sv
